### rtl/kwht_pkg.sv
// Package for the keyed word hash table.
// Holds the command and status codes and the controller state type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package kwht_pkg;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_REPLACE = 2'd1;
  localparam logic [1:0] CMD_GET     = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam int KEY_W   = 32;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP
  } state_t;

endpackage
`default_nettype wire

### rtl/kwht_bucket.sv
// Bucket index unit: key modulo the bucket count.
// Uses kwht_pkg for the key width; a power of two count is combinational.
// Other counts use a reciprocal multiply, a back multiply and one correction.
`timescale 1ns / 1ps
`default_nettype none
module kwht_bucket #(
  parameter int NUM_BUCKETS = 256,
  parameter int BKT_W = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [kwht_pkg::KEY_W-1:0] key,
  output logic                          done,
  output logic [BKT_W-1:0]              bucket
);

  localparam bit IS_POW2 = ((1 << BKT_W) == NUM_BUCKETS);

  generate
    if (IS_POW2) begin : g_pow2
      assign done   = start;
      assign bucket = key[BKT_W-1:0];
    end else begin : g_recip
      localparam logic [63:0] MULT64 = (64'd1 << 32) / 64'(NUM_BUCKETS);
      localparam logic [31:0] MULT   = MULT64[31:0];
      localparam logic [31:0] NB32   = 32'(NUM_BUCKETS);

      logic [2:0]  vld;
      logic [31:0] key1;
      logic [31:0] key2;
      logic [63:0] prod;
      logic [31:0] back;
      logic [31:0] rem;
      logic [31:0] rem_fix;
      logic [BKT_W-1:0] bkt;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld <= '0;
        end else begin
          vld <= {vld[1:0], start};
        end
      end

      always_comb begin
        rem     = key2 - back;
        rem_fix = (rem >= NB32) ? rem - NB32 : rem;
      end

      always_ff @(posedge clk) begin
        key1 <= key;
        prod <= 64'(key) * 64'(MULT);
        key2 <= key1;
        back <= prod[63:32] * NB32;
        bkt  <= rem_fix[BKT_W-1:0];
      end

      assign done   = vld[2];
      assign bucket = bkt;
    end
  endgenerate

endmodule
`default_nettype wire

### rtl/kwht_mem.sv
// Bucket row memory: one write port and one read port with registered data.
// Stands alone; no package is used.
`timescale 1ns / 1ps
`default_nettype none
module kwht_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 260,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/keyed_word_hash_table.sv
// Top level of the keyed word hash table with its command sequencer.
// Depends on kwht_pkg, kwht_bucket and kwht_mem.
//
// A command is taken when start is high and busy is low, and its result shows
// on status, read_word and entries_held for one cycle while done is high; the
// receiver cannot stall it. With a power of two bucket count a command is one
// row read, then compare and write back, so a new command may start in the
// cycle its result appears; other counts first add the registered bucket
// reduction multiplies. The pace is set by the read-modify-write of one bucket
// row in the single row memory and, for other counts, by the multiplies. After
// reset the block stays busy while it clears the valid bits of every row.
`timescale 1ns / 1ps
`default_nettype none
module keyed_word_hash_table #(
  parameter int NUM_BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] lookup_key,
  input  wire logic [31:0] new_word,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      read_word,
  output logic [10:0]      entries_held
);

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KW     = kwht_pkg::KEY_W;
  localparam int DW     = kwht_pkg::WORD_W;
  localparam int ROW_W  = WAYS * (1 + KW + DW);
  localparam int KEY_LO = WAYS * DW;
  localparam int VLD_LO = WAYS * (KW + DW);
  localparam logic [BKT_W-1:0] LAST_ROW = BKT_W'(NUM_BUCKETS - 1);

  kwht_pkg::state_t state;
  kwht_pkg::state_t state_next;

  logic [BKT_W-1:0] clr_cnt;
  logic [1:0]       cmd_r;
  logic [KW-1:0]    key_r;
  logic [DW-1:0]    word_r;
  logic [BKT_W-1:0] row_addr;
  logic [kwht_pkg::COUNT_W-1:0] key_count;

  logic             accept;
  logic             bkt_done;
  logic [BKT_W-1:0] bkt_idx;

  logic             mem_we;
  logic [BKT_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [ROW_W-1:0] mem_rdata;

  logic             hit;
  logic [WAY_W-1:0] hit_idx;
  logic             has_free;
  logic [WAY_W-1:0] free_idx;
  logic             do_insert;
  logic             do_replace;
  logic [ROW_W-1:0] mod_row;
  logic [1:0]       stat_c;
  logic [DW-1:0]    rword_c;
  logic             in_lookup;

  assign accept = start && !busy;

  kwht_bucket #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .BKT_W(BKT_W)
  ) u_bucket (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .key(lookup_key),
    .done(bkt_done),
    .bucket(bkt_idx)
  );

  kwht_mem #(
    .DEPTH(NUM_BUCKETS),
    .WIDTH(ROW_W),
    .ADDR_W(BKT_W)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(bkt_done),
    .raddr(bkt_idx),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      kwht_pkg::ST_CLEAR: begin
        if (clr_cnt == LAST_ROW) begin
          state_next = kwht_pkg::ST_IDLE;
        end
      end
      kwht_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = bkt_done ? kwht_pkg::ST_LOOKUP : kwht_pkg::ST_HASH;
        end
      end
      kwht_pkg::ST_HASH: begin
        if (bkt_done) begin
          state_next = kwht_pkg::ST_LOOKUP;
        end
      end
      kwht_pkg::ST_LOOKUP: begin
        state_next = kwht_pkg::ST_IDLE;
      end
      default: begin
        state_next = kwht_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (mem_rdata[VLD_LO + w]) begin
        if (mem_rdata[KEY_LO + w*KW +: KW] == key_r) begin
          hit     = 1'b1;
          hit_idx = WAY_W'(w);
        end
      end else begin
        has_free = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
  end

  always_comb begin
    do_insert  = (cmd_r == kwht_pkg::CMD_INSERT) && !hit && has_free;
    do_replace = (cmd_r == kwht_pkg::CMD_REPLACE) && hit;
    mod_row    = mem_rdata;
    if (do_insert) begin
      mod_row[VLD_LO + 32'(free_idx)]          = 1'b1;
      mod_row[KEY_LO + 32'(free_idx)*KW +: KW] = key_r;
      mod_row[32'(free_idx)*DW +: DW]          = word_r;
    end else if (do_replace) begin
      mod_row[32'(hit_idx)*DW +: DW] = word_r;
    end
    stat_c  = kwht_pkg::STAT_MISS;
    rword_c = '0;
    case (cmd_r)
      kwht_pkg::CMD_INSERT: begin
        if (hit) begin
          stat_c = kwht_pkg::STAT_MISS;
        end else if (!has_free) begin
          stat_c = kwht_pkg::STAT_FULL;
        end else begin
          stat_c = kwht_pkg::STAT_OK;
        end
      end
      kwht_pkg::CMD_REPLACE: begin
        if (hit) begin
          stat_c = kwht_pkg::STAT_OK;
        end
      end
      kwht_pkg::CMD_GET: begin
        if (hit) begin
          stat_c  = kwht_pkg::STAT_OK;
          rword_c = mem_rdata[32'(hit_idx)*DW +: DW];
        end
      end
      default: begin
        stat_c = kwht_pkg::STAT_MISS;
      end
    endcase
  end

  always_comb begin
    busy      = (state != kwht_pkg::ST_IDLE);
    in_lookup = (state == kwht_pkg::ST_LOOKUP);
    mem_we    = 1'b0;
    mem_waddr = row_addr;
    mem_wdata = mod_row;
    if (state == kwht_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (in_lookup) begin
      mem_we = do_insert || do_replace;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kwht_pkg::ST_CLEAR;
      clr_cnt      <= '0;
      key_count    <= '0;
      done         <= 1'b0;
      entries_held <= '0;
    end else begin
      state <= state_next;
      if (state == kwht_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      done <= in_lookup;
      if (in_lookup) begin
        if (do_insert) begin
          key_count    <= key_count + 1'b1;
          entries_held <= key_count + 1'b1;
        end else begin
          entries_held <= key_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= command;
      key_r  <= lookup_key;
      word_r <= new_word;
    end
    if (bkt_done) begin
      row_addr <= bkt_idx;
    end
    if (in_lookup) begin
      status    <= stat_c;
      read_word <= rword_c;
    end
  end

endmodule
`default_nettype wire

### rtl/kwht_chk.sv
// Port-level checker for the keyed word hash table, with its bind statement.
// Depends on kwht_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none
module kwht_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [31:0] read_word,
  input wire logic [10:0] entries_held
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on two consecutive cycles");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in progress");

  a_word_only_found: assert property (@(posedge clk) disable iff (rst)
    (done && (read_word != 32'd0)) |-> (status == kwht_pkg::STAT_OK))
    else $error("nonzero read_word with a miss or full status");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!done && !$past(rst)) |-> $stable(entries_held))
    else $error("entries_held changed without a result");

endmodule

bind keyed_word_hash_table kwht_chk u_kwht_chk (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .status(status),
  .read_word(read_word),
  .entries_held(entries_held)
);
`default_nettype wire
